>>> hdl/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg: shared types and code table of the HPACK Huffman encoder
// Holds the static Huffman code table (RFC 7541 Appendix B) and widths.
// ----------------------------------------------------------------------------
package hpe_pkg;

	localparam int SymW  = 8;
	localparam int CodeW = 30;
	localparam int LenW  = 5;
	localparam int PendW = 7;
	localparam int RemW  = 3;
	// left-aligned bit buffer: pending (7) + longest code (30) rounded up
	localparam int BufW  = 40;
	localparam int TotW  = 6;
	localparam int CntW  = 3;
	localparam int Depth = 256;

	typedef struct packed {
		logic [CodeW-1:0] code;
		logic [LenW-1:0]  len;
		logic             last;
	} lookup_t;

	localparam logic [CodeW-1:0] CODE_BITS [Depth] = '{
		30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3, 30'hfffffe4, 30'hfffffe5,
		30'hfffffe6, 30'hfffffe7,
		30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9, 30'hfffffea, 30'h3ffffffd,
		30'hfffffeb, 30'hfffffec,
		30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0, 30'hffffff1, 30'hffffff2,
		30'h3ffffffe, 30'hffffff3,
		30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7, 30'hffffff8, 30'hffffff9,
		30'hffffffa, 30'hffffffb,
		30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
		30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
		30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
		30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
		30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
		30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
		30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
		30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
		30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
		30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
		30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
		30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
		30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8, 30'h3fffd3, 30'h3fffd4, 30'h3fffd5,
		30'h7fffd9,
		30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc, 30'h7fffdd, 30'h7fffde, 30'hffffeb,
		30'h7fffdf,
		30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0, 30'hffffee, 30'h7fffe1, 30'h7fffe2,
		30'h7fffe3,
		30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5, 30'h3fffd9, 30'h7fffe6, 30'h7fffe7,
		30'hffffef,
		30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb, 30'h3fffdc, 30'h7fffe8, 30'h7fffe9,
		30'h1fffde,
		30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0, 30'h1fffdf, 30'h3fffdf, 30'h7fffeb,
		30'h7fffec,
		30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2, 30'h7fffed, 30'h3fffe1, 30'h7fffee,
		30'h7fffef,
		30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4, 30'h7ffff0, 30'h3fffe5, 30'h3fffe6,
		30'h7ffff1,
		30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1, 30'h3fffe7, 30'h7ffff2, 30'h3fffe8,
		30'h1ffffec,
		30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde, 30'h7ffffdf, 30'h3ffffe5,
		30'hfffff1, 30'h1ffffed,
		30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0, 30'h7ffffe1, 30'h3ffffe7,
		30'h7ffffe2, 30'hfffff2,
		30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9, 30'hffffffd, 30'h7ffffe3,
		30'h7ffffe4, 30'h7ffffe5,
		30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6, 30'h3fffe9, 30'h1fffe7, 30'h1fffe8,
		30'h7ffff3,
		30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef, 30'hfffff4, 30'hfffff5,
		30'h3ffffea, 30'h7ffff4,
		30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed, 30'h7ffffe7, 30'h7ffffe8,
		30'h7ffffe9, 30'h7ffffea,
		30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed, 30'h7ffffee, 30'h7ffffef,
		30'h7fffff0, 30'h3ffffee
	};

	localparam logic [LenW-1:0] CODE_LEN [Depth] = '{
		13, 23, 28, 28, 28, 28, 28, 28,
		28, 24, 30, 28, 28, 30, 28, 28,
		28, 28, 28, 28, 28, 28, 30, 28,
		28, 28, 28, 28, 28, 28, 28, 28,
		6, 10, 10, 12, 13, 6, 8, 11,
		10, 10, 8, 11, 8, 6, 6, 6,
		5, 5, 5, 6, 6, 6, 6, 6,
		6, 6, 7, 8, 15, 6, 12, 10,
		13, 6, 7, 7, 7, 7, 7, 7,
		7, 7, 7, 7, 7, 7, 7, 7,
		7, 7, 7, 7, 7, 7, 7, 7,
		8, 7, 8, 13, 19, 13, 14, 6,
		15, 5, 6, 5, 6, 5, 6, 6,
		6, 5, 7, 7, 6, 6, 6, 5,
		6, 7, 6, 5, 5, 6, 7, 7,
		7, 7, 7, 15, 11, 14, 13, 28,
		20, 22, 20, 20, 22, 22, 22, 23,
		22, 23, 23, 23, 23, 23, 24, 23,
		24, 24, 22, 23, 24, 23, 23, 23,
		23, 21, 22, 23, 22, 23, 23, 24,
		22, 21, 20, 22, 22, 23, 23, 21,
		23, 22, 22, 24, 21, 22, 23, 23,
		21, 21, 22, 21, 23, 22, 23, 23,
		20, 22, 22, 22, 23, 22, 22, 23,
		26, 26, 20, 19, 22, 23, 22, 25,
		26, 26, 26, 27, 27, 26, 24, 25,
		19, 21, 26, 27, 27, 26, 27, 24,
		21, 21, 26, 26, 28, 27, 27, 27,
		20, 24, 20, 21, 22, 21, 21, 23,
		22, 22, 25, 25, 24, 24, 26, 23,
		26, 27, 26, 26, 27, 27, 27, 27,
		27, 28, 27, 27, 27, 27, 27, 26
	};

endpackage

>>> hdl/hpack_huffman_encoder_unit.sv
// Stages: lookup register (s1), then the emitter buffer (s2) that shows the bytes.
// Throughput: one output byte per cycle while m_tready is high; an item yields
// 0 to 5 bytes, drained from the emitter buffer; the next item loads as its last leaves.
// The lookup stage takes one more beat while bytes drain, then input waits.
// Reset: arst_n asynchronous, active low; clears pending bits and stage valids.
// ----------------------------------------------------------------------------
// hpack_huffman_encoder_unit: HPACK Huffman string encoder
// Table lookup stage followed by the bit packer and byte emitter.
// ----------------------------------------------------------------------------
module hpack_huffman_encoder_unit
	import hpe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic       s_tlast,   // last_symbol
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // final_byte
);

	logic    valid_s1;
	logic    room;
	logic    load;
	logic    rom_en;
	lookup_t lk_s1;

	assign load     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;
	assign rom_en   = s_tvalid && s_tready;

	// lookup stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	hpe_code_rom u_rom (
		.clk     (clk),
		.en      (rom_en),
		.sym     (s_tdata),
		.last    (s_tlast),
		.rd_data (lk_s1)
	);

	hpe_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.lk        (lk_s1),
		.room      (room),
		.out_byte  (m_tdata),
		.out_valid (m_tvalid),
		.out_final (m_tlast),
		.out_ready (m_tready)
	);

endmodule

>>> hdl/hpe_code_rom.sv
// ----------------------------------------------------------------------------
// hpe_code_rom: synchronous code table
// Registered lookup of code, length and last flag; output holds when en is low.
// ----------------------------------------------------------------------------
module hpe_code_rom
	import hpe_pkg::*;
(
	input  logic            clk,
	input  logic            en,
	input  logic [SymW-1:0] sym,
	input  logic            last,
	output lookup_t         rd_data
);

	// registered read; doubles as the s1 payload register
	always_ff @(posedge clk) begin
		if (en) begin
			rd_data.code <= CODE_BITS[sym];
			rd_data.len  <= CODE_LEN[sym];
			rd_data.last <= last;
		end
	end

endmodule

>>> hdl/hpe_packer.sv
// ----------------------------------------------------------------------------
// hpe_packer: bit packer and byte emitter
// Merges a looked-up code behind the pending bits, then drains bytes MSB first.
// ----------------------------------------------------------------------------
module hpe_packer
	import hpe_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  lookup_t         lk,
	output logic            room,
	output logic [SymW-1:0] out_byte,
	output logic            out_valid,
	output logic            out_final,
	input  logic            out_ready
);

	logic [PendW-1:0] pend_bits_q;
	logic [RemW-1:0]  pend_cnt_q;
	logic [BufW-1:0]  buf_s2;
	logic [CntW-1:0]  cnt_s2;
	logic             last_s2;

	logic [BufW-1:0]  acc;
	logic [TotW-1:0]  total;
	logic [TotW-1:0]  gap;
	logic [BufW-1:0]  aligned;
	logic [BufW-1:0]  fill;
	logic [CntW-1:0]  nbytes;
	logic [RemW-1:0]  rem;
	logic [PendW-1:0] new_pend;

	// merge code behind pending bits and left-align in the buffer
	always_comb begin
		acc      = (BufW'(pend_bits_q) << lk.len) | BufW'(lk.code);
		total    = TotW'(pend_cnt_q) + TotW'(lk.len);
		gap      = TotW'(BufW) - total;
		aligned  = acc << gap;
		fill     = (BufW'(1) << gap) - BufW'(1);
		rem      = total[RemW-1:0];
		nbytes   = CntW'(total >> 3) + CntW'(lk.last && (rem != '0));
		new_pend = PendW'(acc) & ((PendW'(1) << rem) - PendW'(1));
	end

	// next load allowed when empty or the final byte leaves now
	assign room = (cnt_s2 == '0) || ((cnt_s2 == CntW'(1)) && out_ready);

	// pending store, updated when a code is merged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (load) begin
			pend_bits_q <= lk.last ? '0 : new_pend;
			pend_cnt_q  <= lk.last ? '0 : rem;
		end
	end

	// byte count of the emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load) begin
			cnt_s2 <= nbytes;
		end else if (out_valid && out_ready) begin
			cnt_s2 <= cnt_s2 - CntW'(1);
		end
	end

	// emitter buffer, shifted one byte per beat
	always_ff @(posedge clk) begin
		if (load) begin
			buf_s2  <= lk.last ? (aligned | fill) : aligned;
			last_s2 <= lk.last;
		end else if (out_valid && out_ready) begin
			buf_s2 <= buf_s2 << 8;
		end
	end

	assign out_valid = (cnt_s2 != '0);
	assign out_byte  = buf_s2[BufW-1 -: SymW];
	assign out_final = last_s2 && (cnt_s2 == CntW'(1));

endmodule

>>> hdl/hpe_checker.sv
// ----------------------------------------------------------------------------
// hpe_checker: port-level checks of the encoder
// Output hold rules, input readiness while the emitter is empty, no output without input.
// ----------------------------------------------------------------------------
module hpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// stalled output beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// empty emitter never blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty emitter");

	// no output without recent input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !(s_tvalid && s_tready) && !$past(s_tvalid && s_tready)
		|=> !m_tvalid)
		else $error("output byte without input");

endmodule

bind hpack_huffman_encoder_unit hpe_checker u_hpe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

>>> bench/hpack_huffman_encoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpack_huffman_encoder_unit_tb: self-checking bench of the HPACK Huffman encoder
// Streams strings of octets through the encoder under several idle/stall
// mixes and compares every output byte and its final flag with a predictor.
// ----------------------------------------------------------------------------

// Predicted encoder state and queue of expected output bytes
class huff_byte_board;
	logic [6:0] held_bits;
	logic [2:0] held_count;
	logic [8:0] byte_q[$];   // {final, byte}
	int         errors;

	function new();
		held_bits  = '0;
		held_count = '0;
		errors     = 0;
	endfunction

	// Pack one symbol's code behind the held bits and queue the completed bytes
	function void note_symbol(logic [7:0] sym, logic last);
		logic [63:0] acc;
		int          len;
		int          total;
		int          n;
		len   = hpe_pkg::CODE_LEN[sym];
		acc   = (64'(held_bits) << len) | 64'(hpe_pkg::CODE_BITS[sym]);
		total = held_count + len;
		n     = 0;
		while (total >= 8) begin
			byte_q.push_back({1'b0, 8'(acc >> (total - 8))});
			n++;
			total -= 8;
		end
		acc &= (64'd1 << total) - 64'd1;
		if (last) begin
			if (total > 0)
				byte_q.push_back({1'b1, 8'((acc << (8 - total)) | (8'hff >> total))});
			else if (n > 0)
				byte_q[$][8] = 1'b1;
			held_bits  = '0;
			held_count = '0;
		end else begin
			held_bits  = acc[6:0];
			held_count = total[2:0];
		end
	endfunction

	// Compare one output beat with the oldest expected byte
	function void check_byte(logic [7:0] data, logic fin);
		logic [8:0] exp_b;
		if (byte_q.size() == 0) begin
			$error("unexpected output byte %02h final %0b", data, fin);
			errors++;
			return;
		end
		exp_b = byte_q.pop_front();
		if (data !== exp_b[7:0]) begin
			$error("out_byte: expected %02h actual %02h", exp_b[7:0], data);
			errors++;
		end
		if (fin !== exp_b[8]) begin
			$error("final_byte: expected %0b actual %0b", exp_b[8], fin);
			errors++;
		end
	endfunction
endclass

module hpack_huffman_encoder_unit_tb;
	import hpe_pkg::*;

	localparam int CycleLimit = 400000;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	huff_byte_board board;
	int             idle_pct;
	int             stall_pct;
	int             cycles = 0;

	hpack_huffman_encoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls, check each accepted beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_byte(m_tdata, m_tlast);
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("** hpack_huffman_encoder_unit: FAILED **");
			$finish;
		end
	end

	// Send one symbol beat, with random idle cycles ahead of it
	task automatic send_symbol(logic [7:0] sym, logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_symbol(sym, last);
	endtask

	// Random string: mostly printable text, sometimes any octet
	task automatic send_string(int len);
		logic [7:0] sym;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(3) == 0)
				sym = 8'($urandom_range(255));
			else
				sym = 8'($urandom_range(126, 32));
			send_symbol(sym, i == len - 1);
		end
	endtask

	initial begin
		int sent;
		board     = new();
		idle_pct  = 0;
		stall_pct = 0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-symbol strings, shortest and longest codes,
		// byte-aligned ending ('0' x8 = 40 bits), long codes back to back
		send_symbol(8'd48, 1'b1);
		send_symbol(8'd10, 1'b1);
		send_symbol(8'd255, 1'b1);
		send_symbol(8'd0, 1'b1);
		for (int i = 0; i < 8; i++) send_symbol(8'd48, i == 7);
		send_symbol(8'd38, 1'b1);
		send_symbol(8'd13, 1'b0);
		send_symbol(8'd22, 1'b0);
		send_symbol(8'd10, 1'b0);
		send_symbol(8'd1, 1'b1);
		send_symbol(8'd97, 1'b0);
		send_symbol(8'd128, 1'b0);
		send_symbol(8'd127, 1'b1);

		// Random phases with different idle/stall mixes
		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 60; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 60; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			while (sent < 92 * (ph + 1)) begin
				int len;
				len = $urandom_range(12, 1);
				send_string(len);
				sent += len;
			end
		end
		s_tvalid <= 1'b0;

		// Drain
		while (board.byte_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("** hpack_huffman_encoder_unit: PASSED **");
		else
			$display("** hpack_huffman_encoder_unit: FAILED **");
		$finish;
	end

endmodule
